// ----- rtl/core/sff_pkg.sv -----
// Shared types, codes and helper functions for the stateful flow firewall.
// No dependencies; compiled first.
package sff_pkg;

   // Default table sizes for the top level
   localparam int DEF_FLOW_ENTRIES = 64;
   localparam int DEF_RULE_ENTRIES = 16;

   // Field widths
   localparam int ADDR_W  = 32;
   localparam int PORT_W  = 16;
   localparam int PROTO_W = 8;
   localparam int LIFE_W  = 16;
   localparam int TIME_W  = 32;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [PROTO_W-1:0] ICMP_PROTO = 8'd1;
   localparam logic [LIFE_W-1:0]  LIFE_MAX   = 16'hFFFF;
   localparam logic [LIFE_W-1:0]  RESET_LIFETIME = 16'd5;

   typedef enum logic [1:0] {
      OP_PACKET = 2'd0,
      OP_RULE   = 2'd1,
      OP_TICK   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      VERDICT_FORWARD = 2'd0,
      VERDICT_DROP    = 2'd1,
      VERDICT_REFUSE  = 2'd2,
      VERDICT_ACK     = 2'd3
   } verdict_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_LIFE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIFE_EXT  = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0]  src;
      logic [ADDR_W-1:0]  dst;
      logic [PROTO_W-1:0] proto;
      logic [PORT_W-1:0]  sport;
      logic [PORT_W-1:0]  dport;
   } tuple_type;

   // Reverse direction: swap addresses and ports, keep the protocol
   function automatic tuple_type inverse_of(input tuple_type t);
      tuple_type r;
      r.src   = t.dst;
      r.dst   = t.src;
      r.proto = t.proto;
      r.sport = t.dport;
      r.dport = t.sport;
      return r;
   endfunction

   // Wildcard rule compare: zero fields match anything, ICMP skips ports
   function automatic logic rule_match(input tuple_type r, input tuple_type t);
      logic head_ok;
      logic port_ok;
      head_ok = (r.dst == '0 || r.dst == t.dst) && (r.src == '0 || r.src == t.src) &&
                (r.proto == '0 || r.proto == t.proto);
      port_ok = (t.proto == ICMP_PROTO) ||
                ((r.dport == '0 || r.dport == t.dport) && (r.sport == '0 || r.sport == t.sport));
      return head_ok && port_ok;
   endfunction

   // Lifetime plus extension, saturating
   function automatic logic [LIFE_W-1:0] sat_add(input logic [LIFE_W-1:0] a,
                                                 input logic [LIFE_W-1:0] b);
      logic [LIFE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LIFE_W] ? LIFE_MAX : s[LIFE_W-1:0];
   endfunction

endpackage

// ----- rtl/core/sff_if.sv -----
// Channel interfaces of the stateful flow firewall: request, response, CSR write.
// Depends on sff_pkg.
interface sff_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic [sff_pkg::SLOT_W-1:0]  rule_slot;
   logic [sff_pkg::ADDR_W-1:0]  src_addr;
   logic [sff_pkg::ADDR_W-1:0]  dst_addr;
   logic [sff_pkg::PROTO_W-1:0] proto;
   logic [sff_pkg::PORT_W-1:0]  sport;
   logic [sff_pkg::PORT_W-1:0]  dport;
   logic                        from_outside;
   modport source (output valid, opcode, rule_slot, src_addr, dst_addr, proto, sport,
                   dport, from_outside, input ready);
   modport sink (input valid, opcode, rule_slot, src_addr, dst_addr, proto, sport,
                 dport, from_outside, output ready);
endinterface

interface sff_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  verdict;
   logic                        flow_hit;
   logic                        rule_hit;
   logic [sff_pkg::COUNT_W-1:0] flows_in_use;
   modport source (output valid, verdict, flow_hit, rule_hit, flows_in_use, input ready);
   modport sink (input valid, verdict, flow_hit, rule_hit, flows_in_use, output ready);
endinterface

interface sff_csr_if;
   logic                          valid;
   logic                          ready;
   logic [sff_pkg::CSR_IDX_W-1:0] index;
   logic [sff_pkg::LIFE_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/stateful_flow_firewall_unit.sv -----
// Stateful flow firewall: connection tracking table plus wildcard exception rules.
// Depends on sff_pkg and the channel interfaces in sff_if.sv.
//
//   channel  | dir | transaction
//   ---------+-----+------------------------------------------------
//   req_ch   | in  | packet tuple, rule write or one-second tick
//   rsp_ch   | out | verdict, hit flags, flows in use
//   csr_ch   | in  | lifetime register write, always ready
//
// A tick, rule write or unknown opcode passes straight to the response state. A packet
// takes a flow lookup over all FLOW_ENTRIES keys (one key memory read per cycle), then
// a rule walk over RULE_ENTRIES on an outside miss, then an expiry sweep when the table
// is nearly full, then a refresh of both directions or an insert of the pair.
// Reset is synchronous and clears the valid bits at once; no clearing pass is needed.
// req_ch is ready only in idle; a finished result waits in the output register while
// the next transaction is taken, and the block stalls at the end of an item until it
// leaves.
module stateful_flow_firewall_unit #(
   parameter int FLOW_ENTRIES = sff_pkg::DEF_FLOW_ENTRIES,
   parameter int RULE_ENTRIES = sff_pkg::DEF_RULE_ENTRIES
) (
   input logic clock,
   input logic reset,
   sff_req_if.sink   req_ch,
   sff_rsp_if.source rsp_ch,
   sff_csr_if.sink   csr_ch
);
   import sff_pkg::*;

   localparam int FW = $clog2(FLOW_ENTRIES);
   localparam int RW = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
   localparam int IW = (FW > RW) ? FW : RW;
   localparam int CW = $clog2(FLOW_ENTRIES + 1);
   localparam int MW = TIME_W + LIFE_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FSCAN, ST_RSCAN, ST_CHECK, ST_SWEEP,
      ST_STORE0, ST_STORE1, ST_RF_RD, ST_RF_WR, ST_RESP
   } state_type;

   // Memories
   tuple_type             key_mem  [FLOW_ENTRIES];
   logic [MW-1:0]         meta_mem [FLOW_ENTRIES];
   tuple_type             rule_mem [RULE_ENTRIES];
   tuple_type             key_rd_ff;
   logic [MW-1:0]         meta_rd_ff;
   tuple_type             rule_rd_ff;

   // Control and datapath registers
   state_type             state_ff, state_in;
   logic [FLOW_ENTRIES-1:0] used_ff, used_in;
   logic [RULE_ENTRIES-1:0] rule_used_ff, rule_used_in;
   logic [CW-1:0]         total_ff, total_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [LIFE_W-1:0]     init_life_ff, init_life_in;
   logic [LIFE_W-1:0]     life_ext_ff, life_ext_in;
   tuple_type             tup_ff, tup_in;
   logic                  outside_ff, outside_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  issue_ff, issue_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                  hit_t_ok_ff, hit_t_ok_in, hit_i_ok_ff, hit_i_ok_in;
   logic [FW-1:0]         hit_t_ff, hit_t_in, hit_i_ff, hit_i_in;
   logic                  free0_ok_ff, free0_ok_in, free1_ok_ff, free1_ok_in;
   logic [FW-1:0]         free0_ff, free0_in, free1_ff, free1_in;
   logic                  swept_ff, swept_in;
   logic                  pass_ff, pass_in;
   logic                  fhit_ff, fhit_in, rhit_ff, rhit_in;
   verdict_type           verdict_ff, verdict_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_verdict_ff, rsp_verdict_in;
   logic                  rsp_fhit_ff, rsp_fhit_in, rsp_rhit_ff, rsp_rhit_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   // Memory ports
   logic                  key_we, meta_we, rule_we;
   logic [FW-1:0]         key_waddr, meta_waddr, meta_raddr;
   tuple_type             key_wdata;
   logic [MW-1:0]         meta_wdata;

   tuple_type             tup_inv;
   tuple_type             req_tup;
   logic [IW-1:0]         scan_last;
   logic                  scan_end;
   logic [FW-1:0]         cmp_fidx;
   logic [TIME_W-1:0]     age;
   logic                  expired;
   logic                  entry_free;

   assign tup_inv = inverse_of(tup_ff);
   assign req_tup = '{src: req_ch.src_addr, dst: req_ch.dst_addr, proto: req_ch.proto,
                      sport: req_ch.sport, dport: req_ch.dport};
   assign scan_last = (state_ff == ST_RSCAN) ? IW'(RULE_ENTRIES - 1) : IW'(FLOW_ENTRIES - 1);
   assign scan_end  = cmp_vld_ff && (cmp_idx_ff == scan_last);
   assign cmp_fidx  = cmp_idx_ff[FW-1:0];
   assign age       = now_ff - meta_rd_ff[MW-1:LIFE_W];
   assign expired   = used_ff[cmp_fidx] && (age > TIME_W'(meta_rd_ff[LIFE_W-1:0]));
   assign meta_raddr = (state_ff == ST_RF_RD) ? (pass_ff ? hit_i_ff : hit_t_ff)
                                              : idx_ff[FW-1:0];

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.verdict      = rsp_verdict_ff;
   assign rsp_ch.flow_hit     = rsp_fhit_ff;
   assign rsp_ch.rule_hit     = rsp_rhit_ff;
   assign rsp_ch.flows_in_use = rsp_count_ff;

   // Flow key, flow metadata and rule memories: one write, one registered read
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      key_rd_ff <= key_mem[idx_ff[FW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (rule_we) begin
         rule_mem[RW'(req_ch.rule_slot)] <= req_tup;
      end
      rule_rd_ff <= rule_mem[idx_ff[RW-1:0]];
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      used_in = used_ff;
      rule_used_in = rule_used_ff;
      total_in = total_ff;
      now_in = now_ff;
      init_life_in = init_life_ff;
      life_ext_in = life_ext_ff;
      tup_in = tup_ff;
      outside_in = outside_ff;
      idx_in = idx_ff;
      issue_in = issue_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      hit_t_ok_in = hit_t_ok_ff;
      hit_t_in = hit_t_ff;
      hit_i_ok_in = hit_i_ok_ff;
      hit_i_in = hit_i_ff;
      free0_ok_in = free0_ok_ff;
      free0_in = free0_ff;
      free1_ok_in = free1_ok_ff;
      free1_in = free1_ff;
      swept_in = swept_ff;
      pass_in = pass_ff;
      fhit_in = fhit_ff;
      rhit_in = rhit_ff;
      verdict_in = verdict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_fhit_in = rsp_fhit_ff;
      rsp_rhit_in = rsp_rhit_ff;
      rsp_count_in = rsp_count_ff;
      key_we = 1'b0;
      key_waddr = free0_ff;
      key_wdata = tup_ff;
      meta_we = 1'b0;
      meta_waddr = free0_ff;
      meta_wdata = {now_ff, init_life_ff};
      rule_we = 1'b0;
      entry_free = 1'b0;

      // Configuration writes
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_INIT_LIFE: init_life_in = csr_ch.data;
            CSR_LIFE_EXT:  life_ext_in = csr_ch.data;
            default: ;
         endcase
      end

      // Advance the shared scan pointer
      if (state_ff == ST_FSCAN || state_ff == ST_RSCAN || state_ff == ST_SWEEP) begin
         if (issue_ff) begin
            cmp_vld_in = 1'b1;
            cmp_idx_in = idx_ff;
            if (idx_ff == scan_last) begin
               issue_in = 1'b0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               tup_in = req_tup;
               outside_in = req_ch.from_outside;
               fhit_in = 1'b0;
               rhit_in = 1'b0;
               swept_in = 1'b0;
               pass_in = 1'b0;
               idx_in = '0;
               issue_in = 1'b0;
               state_in = ST_RESP;
               unique case (opcode_type'(req_ch.opcode))
                  OP_PACKET: begin
                     issue_in = 1'b1;
                     hit_t_ok_in = 1'b0;
                     hit_i_ok_in = 1'b0;
                     free0_ok_in = 1'b0;
                     free1_ok_in = 1'b0;
                     state_in = ST_FSCAN;
                  end
                  OP_RULE: begin
                     if (32'(req_ch.rule_slot) < RULE_ENTRIES) begin
                        rule_we = 1'b1;
                        rule_used_in[RW'(req_ch.rule_slot)] = 1'b1;
                     end
                     verdict_in = VERDICT_ACK;
                  end
                  OP_TICK: begin
                     now_in = now_ff + 1'b1;
                     verdict_in = VERDICT_ACK;
                  end
                  default: verdict_in = VERDICT_DROP;
               endcase
            end
         end
         ST_FSCAN: begin
            // Record first tuple hit, first inverse hit and two lowest free slots
            if (cmp_vld_ff) begin
               if (used_ff[cmp_fidx]) begin
                  if (!hit_t_ok_ff && key_rd_ff == tup_ff) begin
                     hit_t_ok_in = 1'b1;
                     hit_t_in = cmp_fidx;
                  end
                  if (!hit_i_ok_ff && key_rd_ff == tup_inv) begin
                     hit_i_ok_in = 1'b1;
                     hit_i_in = cmp_fidx;
                  end
               end else if (!free0_ok_ff) begin
                  free0_ok_in = 1'b1;
                  free0_in = cmp_fidx;
               end else if (!free1_ok_ff) begin
                  free1_ok_in = 1'b1;
                  free1_in = cmp_fidx;
               end
            end
            if (scan_end) begin
               if (hit_t_ok_in) begin
                  fhit_in = 1'b1;
                  state_in = ST_RF_RD;
               end else if (outside_ff) begin
                  idx_in = '0;
                  issue_in = 1'b1;
                  state_in = ST_RSCAN;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_RSCAN: begin
            if (cmp_vld_ff && rule_used_ff[cmp_idx_ff[RW-1:0]] &&
                rule_match(rule_rd_ff, tup_ff)) begin
               rhit_in = 1'b1;
            end
            if (scan_end) begin
               if (rhit_in) begin
                  state_in = ST_CHECK;
               end else begin
                  verdict_in = VERDICT_DROP;
                  state_in = ST_RESP;
               end
            end
         end
         ST_CHECK: begin
            if (total_ff > CW'(FLOW_ENTRIES - 2)) begin
               if (swept_ff) begin
                  verdict_in = VERDICT_REFUSE;
                  state_in = ST_RESP;
               end else begin
                  idx_in = '0;
                  issue_in = 1'b1;
                  free0_ok_in = 1'b0;
                  free1_ok_in = 1'b0;
                  state_in = ST_SWEEP;
               end
            end else begin
               state_in = ST_STORE0;
            end
         end
         ST_SWEEP: begin
            // Drop expired entries and rebuild the free slot picks
            if (cmp_vld_ff) begin
               entry_free = !used_ff[cmp_fidx] || expired;
               if (expired) begin
                  used_in[cmp_fidx] = 1'b0;
                  total_in = total_ff - 1'b1;
               end
               if (entry_free && !free0_ok_ff) begin
                  free0_ok_in = 1'b1;
                  free0_in = cmp_fidx;
               end else if (entry_free && !free1_ok_ff) begin
                  free1_ok_in = 1'b1;
                  free1_in = cmp_fidx;
               end
            end
            if (scan_end) begin
               swept_in = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_STORE0: begin
            key_we = 1'b1;
            meta_we = 1'b1;
            used_in[free0_ff] = 1'b1;
            total_in = total_ff + 1'b1;
            state_in = ST_STORE1;
         end
         ST_STORE1: begin
            key_we = 1'b1;
            key_waddr = free1_ff;
            key_wdata = tup_inv;
            meta_we = 1'b1;
            meta_waddr = free1_ff;
            used_in[free1_ff] = 1'b1;
            total_in = total_ff + 1'b1;
            verdict_in = VERDICT_FORWARD;
            state_in = ST_RESP;
         end
         ST_RF_RD: begin
            state_in = ST_RF_WR;
         end
         ST_RF_WR: begin
            // Extend the tuple entry, then the inverse entry if it is present
            meta_we = 1'b1;
            meta_waddr = pass_ff ? hit_i_ff : hit_t_ff;
            meta_wdata = {meta_rd_ff[MW-1:LIFE_W],
                          sat_add(meta_rd_ff[LIFE_W-1:0], life_ext_ff)};
            if (!pass_ff && hit_i_ok_ff) begin
               pass_in = 1'b1;
               state_in = ST_RF_RD;
            end else begin
               verdict_in = VERDICT_FORWARD;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_verdict_in = verdict_ff;
               rsp_fhit_in = fhit_ff;
               rsp_rhit_in = rhit_ff;
               rsp_count_in = COUNT_W'(total_ff);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff <= '0;
         rule_used_ff <= '0;
         total_ff <= '0;
         now_ff <= '0;
         init_life_ff <= RESET_LIFETIME;
         life_ext_ff <= RESET_LIFETIME;
         issue_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         rule_used_ff <= rule_used_in;
         total_ff <= total_in;
         now_ff <= now_in;
         init_life_ff <= init_life_in;
         life_ext_ff <= life_ext_in;
         issue_ff <= issue_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tup_ff <= tup_in;
      outside_ff <= outside_in;
      idx_ff <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_t_ok_ff <= hit_t_ok_in;
      hit_t_ff <= hit_t_in;
      hit_i_ok_ff <= hit_i_ok_in;
      hit_i_ff <= hit_i_in;
      free0_ok_ff <= free0_ok_in;
      free0_ff <= free0_in;
      free1_ok_ff <= free1_ok_in;
      free1_ff <= free1_in;
      swept_ff <= swept_in;
      pass_ff <= pass_in;
      fhit_ff <= fhit_in;
      rhit_ff <= rhit_in;
      verdict_ff <= verdict_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_fhit_ff <= rsp_fhit_in;
      rsp_rhit_ff <= rsp_rhit_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Flow count tracks the valid bits
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == 32'(total_ff))
      else $error("flow count differs from valid bits");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= FLOW_ENTRIES)
      else $error("flow count above table size");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response raised outside response state");

   a_insert_has_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STORE0 |-> free0_ok_ff && free1_ok_ff)
      else $error("insert without two free slots");

endmodule

// ----- test/tb.sv -----
// Self-checking regression bench for stateful_flow_firewall_unit: a queue-fed driver,
// a monitor with a cycle-free flow table predictor, and lifetime register phases.
// Depends on sff_pkg, sff_if.sv and the firewall RTL.
`timescale 1ns / 100ps

module tb;
   import sff_pkg::*;

   localparam int FLOWS = DEF_FLOW_ENTRIES;
   localparam int RULES = DEF_RULE_ENTRIES;

   typedef struct {
      logic [1:0]        opcode;
      logic [SLOT_W-1:0] slot;
      tuple_type         tup;
      logic              outside;
   } fw_item_type;

   typedef struct {
      verdict_type        verdict;
      logic               flow_hit;
      logic               rule_hit;
      logic [COUNT_W-1:0] in_use;
   } fw_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sff_req_if req_if ();
   sff_rsp_if rsp_if ();
   sff_csr_if csr_if ();

   stateful_flow_firewall_unit dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_ch(csr_if)
   );

   // Shadow copy of the firewall state
   tuple_type         tbl_key   [FLOWS];
   logic [TIME_W-1:0] tbl_stamp [FLOWS];
   logic [LIFE_W-1:0] tbl_life  [FLOWS];
   logic              tbl_used  [FLOWS];
   int                tbl_total;
   logic [TIME_W-1:0] clock_secs;
   tuple_type         acl_key   [RULES];
   logic              acl_used  [RULES];
   logic [LIFE_W-1:0] new_life;
   logic [LIFE_W-1:0] ext_life;

   fw_item_type    pending_items[$];
   fw_verdict_type expected_verdicts[$];

   int errors = 0;
   int cyc = 0;
   int req_accepts = 0;
   int req_sent = 0;
   int n_forward = 0, n_drop = 0, n_refuse = 0, n_flow_hit = 0, n_rule_hit = 0;
   logic [31:0] addr_pool [8];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------- predictor ----------------
   function automatic int lookup_flow(tuple_type t);
      for (int i = 0; i < FLOWS; i++)
         if (tbl_used[i] && tbl_key[i] == t) return i;
      return -1;
   endfunction

   function automatic void refresh_life(tuple_type t);
      int i;
      logic [LIFE_W:0] s;
      i = lookup_flow(t);
      if (i < 0) return;
      s = {1'b0, tbl_life[i]} + {1'b0, ext_life};
      tbl_life[i] = s[LIFE_W] ? 16'hFFFF : s[LIFE_W-1:0];
   endfunction

   function automatic void insert_flow(tuple_type t);
      for (int i = 0; i < FLOWS; i++)
         if (!tbl_used[i]) begin
            tbl_used[i]  = 1'b1;
            tbl_key[i]   = t;
            tbl_stamp[i] = clock_secs;
            tbl_life[i]  = new_life;
            tbl_total++;
            return;
         end
   endfunction

   function automatic logic acl_permits(tuple_type t);
      for (int i = 0; i < RULES; i++) begin
         if (!acl_used[i]) continue;
         if ((acl_key[i].dst != 0 && acl_key[i].dst != t.dst) ||
             (acl_key[i].src != 0 && acl_key[i].src != t.src) ||
             (acl_key[i].proto != 0 && acl_key[i].proto != t.proto)) continue;
         if (t.proto == ICMP_PROTO) return 1'b1;
         if ((acl_key[i].dport == 0 || acl_key[i].dport == t.dport) &&
             (acl_key[i].sport == 0 || acl_key[i].sport == t.sport)) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic verdict_type track_flow(tuple_type t, ref logic hit);
      tuple_type rev;
      rev.src = t.dst; rev.dst = t.src; rev.proto = t.proto;
      rev.sport = t.dport; rev.dport = t.sport;
      if (lookup_flow(t) >= 0) begin
         refresh_life(t);
         refresh_life(rev);
         hit = 1'b1;
         return VERDICT_FORWARD;
      end
      if (tbl_total > FLOWS - 2) begin
         // sweep expired entries one by one
         for (int i = 0; i < FLOWS; i++)
            if (tbl_used[i] && (clock_secs - tbl_stamp[i]) > {16'd0, tbl_life[i]}) begin
               tbl_used[i] = 1'b0;
               tbl_total--;
            end
         if (tbl_total > FLOWS - 2) return VERDICT_REFUSE;
      end
      insert_flow(t);
      insert_flow(rev);
      return VERDICT_FORWARD;
   endfunction

   function automatic fw_verdict_type filter_item(fw_item_type it);
      fw_verdict_type r;
      logic hit;
      hit = 1'b0;
      r.rule_hit = 1'b0;
      r.verdict = VERDICT_DROP;
      case (it.opcode)
         OP_PACKET: begin
            if (!it.outside || lookup_flow(it.tup) >= 0) r.verdict = track_flow(it.tup, hit);
            else if (acl_permits(it.tup)) begin
               r.rule_hit = 1'b1;
               r.verdict = track_flow(it.tup, hit);
            end
         end
         OP_RULE: begin
            acl_key[it.slot]  = it.tup;
            acl_used[it.slot] = 1'b1;
            r.verdict = VERDICT_ACK;
         end
         OP_TICK: begin
            clock_secs = clock_secs + 1;
            r.verdict = VERDICT_ACK;
         end
         default: r.verdict = VERDICT_DROP;
      endcase
      r.flow_hit = hit;
      r.in_use = tbl_total[COUNT_W-1:0];
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic fw_item_type make_item(logic [1:0] op, logic [31:0] s, logic [31:0] d,
                                             logic [7:0] p, logic [15:0] sp, logic [15:0] dp,
                                             logic outside, logic [SLOT_W-1:0] slot);
      fw_item_type it;
      it.opcode = op; it.slot = slot; it.outside = outside;
      it.tup.src = s; it.tup.dst = d; it.tup.proto = p;
      it.tup.sport = sp; it.tup.dport = dp;
      return it;
   endfunction

   function automatic logic [15:0] pool_port();
      logic [15:0] ports [4];
      ports = '{16'd0, 16'd80, 16'd443, 16'hFFFF};
      return ports[2'($urandom_range(3))];
   endfunction

   function automatic logic [7:0] pool_proto();
      logic [7:0] protos [4];
      protos = '{8'd1, 8'd6, 8'd17, 8'hFF};
      return protos[2'($urandom_range(3))];
   endfunction

   function automatic logic [31:0] pool_addr();
      return addr_pool[3'($urandom_range(7))];
   endfunction

   function automatic fw_item_type random_item();
      fw_item_type it;
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) begin
         // fully random noise, any opcode
         it = make_item(2'($urandom_range(3)), $urandom, $urandom, 8'($urandom),
                        16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                        SLOT_W'($urandom));
      end else if (pick < 13) begin
         // rule with per-field wildcards
         it = make_item(OP_RULE,
                        ($urandom_range(9) < 3) ? 32'd0 : pool_addr(),
                        ($urandom_range(9) < 3) ? 32'd0 : pool_addr(),
                        ($urandom_range(9) < 3) ? 8'd0 : pool_proto(),
                        pool_port(), pool_port(), 1'($urandom_range(1)),
                        SLOT_W'($urandom));
      end else if (pick < 28) begin
         it = make_item(OP_TICK, $urandom, $urandom, 8'($urandom), 16'($urandom),
                        16'($urandom), 1'($urandom_range(1)), SLOT_W'($urandom));
      end else begin
         it = make_item(OP_PACKET, pool_addr(), pool_addr(), pool_proto(), pool_port(),
                        pool_port(), 1'($urandom_range(1)), SLOT_W'($urandom));
      end
      return it;
   endfunction

   // ---------------- request driver ----------------
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && req_accepts != req_sent) begin
         // hold the offered transaction
      end else if (pending_items.size() != 0 &&
                   (((cyc % 4000) < 700) || $urandom_range(99) >= 36)) begin
         fw_item_type it;
         it = pending_items.pop_front();
         req_if.valid        <= 1'b1;
         req_if.opcode       <= it.opcode;
         req_if.rule_slot    <= it.slot;
         req_if.src_addr     <= it.tup.src;
         req_if.dst_addr     <= it.tup.dst;
         req_if.proto        <= it.tup.proto;
         req_if.sport        <= it.tup.sport;
         req_if.dport        <= it.tup.dport;
         req_if.from_outside <= it.outside;
         req_sent++;
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // ---------------- response receiver with one long hold-off ----------------
   int hold_left = 0;
   logic hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (!hold_done && req_accepts >= 330) begin
         hold_done = 1'b1;
         hold_left = 2500;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ((cyc % 4000) < 700) || ($urandom_range(99) >= 36);
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      cyc++;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            if (csr_if.index == CSR_INIT_LIFE) new_life = csr_if.data;
            else ext_life = csr_if.data;
         end
         if (req_if.valid && req_if.ready) begin
            fw_item_type it;
            it = make_item(req_if.opcode, req_if.src_addr, req_if.dst_addr, req_if.proto,
                           req_if.sport, req_if.dport, req_if.from_outside,
                           req_if.rule_slot);
            expected_verdicts.push_back(filter_item(it));
            req_accepts++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            fw_verdict_type e;
            if (expected_verdicts.size() == 0) begin
               errors++;
               $display("%0t: unexpected response verdict=%0d", $time, rsp_if.verdict);
            end else begin
               e = expected_verdicts.pop_front();
               if (rsp_if.verdict !== e.verdict || rsp_if.flow_hit !== e.flow_hit ||
                   rsp_if.rule_hit !== e.rule_hit || rsp_if.flows_in_use !== e.in_use) begin
                  errors++;
                  $display({"%0t: mismatch expected v=%0d fh=%0b rh=%0b use=%0d,",
                            " actual v=%0d fh=%0b rh=%0b use=%0d"},
                           $time, e.verdict, e.flow_hit, e.rule_hit, e.in_use,
                           rsp_if.verdict, rsp_if.flow_hit, rsp_if.rule_hit,
                           rsp_if.flows_in_use);
               end
               case (e.verdict)
                  VERDICT_FORWARD: n_forward++;
                  VERDICT_DROP:    n_drop++;
                  VERDICT_REFUSE:  n_refuse++;
                  default: ;
               endcase
               n_flow_hit += e.flow_hit;
               n_rule_hit += e.rule_hit;
            end
         end
      end
   end

   // ---------------- sequencing ----------------
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_accepts != req_sent || req_if.valid ||
             expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [LIFE_W-1:0] val);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic queue_random(int count);
      repeat (count) pending_items.push_back(random_item());
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.opcode = OP_NONE;
      req_if.rule_slot = '0;
      req_if.src_addr = '0;
      req_if.dst_addr = '0;
      req_if.proto = '0;
      req_if.sport = '0;
      req_if.dport = '0;
      req_if.from_outside = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_INIT_LIFE;
      csr_if.data = '0;
      addr_pool = '{32'h0, 32'hFFFF_FFFF, 32'h0A00_0001, 32'h0A00_0002,
                    32'hC0A8_0101, 32'hC0A8_0102, 32'h0808_0808, 32'h8000_0000};
      for (int i = 0; i < FLOWS; i++) tbl_used[i] = 1'b0;
      for (int i = 0; i < RULES; i++) acl_used[i] = 1'b0;
      tbl_total = 0;
      clock_secs = '0;
      new_life = RESET_LIFETIME;
      ext_life = RESET_LIFETIME;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: drops, extremes, refresh, self-inverse pair, rules, ICMP, odd opcode
      pending_items.push_back(make_item(OP_PACKET, 32'h0A00_0001, 32'h0808_0808, 8'd6,
                                        16'd1234, 16'd80, 1'b1, 4'd0));
      pending_items.push_back(make_item(OP_PACKET, '1, '1, 8'hFF, '1, 16'h0, 1'b0, 4'hF));
      pending_items.push_back(make_item(OP_PACKET, '1, '1, 8'hFF, '1, 16'h0, 1'b0, 4'hF));
      pending_items.push_back(make_item(OP_PACKET, '1, '1, 8'hFF, 16'h0, '1, 1'b1, 4'h0));
      pending_items.push_back(make_item(OP_PACKET, 32'h0, 32'h0, 8'h0, 16'h0, 16'h0,
                                        1'b0, 4'h0));
      pending_items.push_back(make_item(OP_PACKET, 32'h0A00_0002, 32'h0A00_0002, 8'd17,
                                        16'd53, 16'd53, 1'b0, 4'h0));
      pending_items.push_back(make_item(OP_PACKET, 32'h0A00_0002, 32'h0A00_0002, 8'd17,
                                        16'd53, 16'd53, 1'b1, 4'h0));
      pending_items.push_back(make_item(OP_RULE, 32'h0, 32'hC0A8_0101, 8'd1, 16'd7,
                                        16'd9, 1'b0, 4'd0));
      pending_items.push_back(make_item(OP_PACKET, 32'h0808_0808, 32'hC0A8_0101, 8'd1,
                                        16'hFFFF, 16'd3, 1'b1, 4'd0));
      pending_items.push_back(make_item(OP_RULE, 32'h0, 32'h0, 8'd6, 16'd0, 16'd443,
                                        1'b1, 4'd15));
      pending_items.push_back(make_item(OP_PACKET, 32'h0808_0808, 32'hC0A8_0102, 8'd6,
                                        16'd5555, 16'd443, 1'b1, 4'd0));
      pending_items.push_back(make_item(OP_PACKET, 32'h0808_0808, 32'hC0A8_0102, 8'd6,
                                        16'd5555, 16'd444, 1'b1, 4'd0));
      pending_items.push_back(make_item(OP_RULE, '1, '1, 8'hFF, '1, '1, 1'b1, 4'd15));
      pending_items.push_back(make_item(OP_PACKET, 32'h0808_0808, 32'hC0A8_0102, 8'd6,
                                        16'd5555, 16'd443, 1'b1, 4'd0));
      pending_items.push_back(make_item(OP_NONE, '1, '1, 8'hFF, '1, '1, 1'b1, 4'hF));
      repeat (8) pending_items.push_back(make_item(OP_TICK, '0, '0, '0, '0, '0, 1'b0, 4'd0));
      pending_items.push_back(make_item(OP_PACKET, '1, '1, 8'hFF, '1, 16'h0, 1'b0, 4'hF));
      queue_random(140);
      wait_idle();

      // initial lifetime of 1, no extension
      write_csr(CSR_INIT_LIFE, 16'd1);
      write_csr(CSR_LIFE_EXT, 16'd0);
      queue_random(120);
      wait_idle();

      // largest lifetimes, saturating refresh; the long response hold-off lands here
      write_csr(CSR_INIT_LIFE, 16'hFFFF);
      write_csr(CSR_LIFE_EXT, 16'hFFFF);
      queue_random(130);
      wait_idle();

      $display("covered %0d requests: %0d forward, %0d drop, %0d refuse", req_accepts,
               n_forward, n_drop, n_refuse);
      $display("flow hits %0d, rule hits %0d, errors %0d", n_flow_hit, n_rule_hit, errors);
      if (errors == 0)
         $display("stateful_flow_firewall_unit regression: pass");
      else
         $display("stateful_flow_firewall_unit regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("stateful_flow_firewall_unit regression: fail");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/sff_pkg.sv
rtl/core/sff_if.sv
rtl/core/stateful_flow_firewall_unit.sv
test/tb.sv
